[rtl/cdeq_pkg.sv]
// Shared constants, types and index helpers for the circular deque.
package cdeq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [1:0] ACT_PUSH_LEFT  = 2'd0;
   localparam logic [1:0] ACT_PUSH_RIGHT = 2'd1;
   localparam logic [1:0] ACT_POP_LEFT   = 2'd2;
   localparam logic [1:0] ACT_POP_RIGHT  = 2'd3;

   typedef enum logic [1:0] {
      ST_SHOWN = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] data;
   } cdeq_wr_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

[rtl/circular_deque_with_dump.sv]
// Top level of the circular deque with full contents dump after each update that leaves items in the store.
//
// An item (push left, push right, pop left, pop right) is taken when start is
// high and busy is low. A successful update that leaves items in the store
// sends the whole contents front to rear, one result per cycle, with last on
// the final one; busy falls in the cycle of that final result. The single
// read port of the ring store gives one element per cycle. A push to a full
// store, a pop from an empty store, or a pop that leaves the store empty gives
// one result in the cycle after acceptance and busy stays low. Results appear
// on the rsp_ ports for one cycle marked by rsp_strobe and cannot be held off.
module circular_deque_with_dump
   import cdeq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last,
   output logic                     rsp_is_full,
   output logic                     rsp_is_empty
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             strobe_ff, strobe_in;
   status_type       status_ff, status_in;
   logic             last_ff, last_in;
   logic             full_ff, full_in;
   logic             empty_ff, empty_in;

   logic                     accept;
   logic                     err;
   status_type               err_status;
   cdeq_wr_type              wr;
   logic                     rd_en;
   logic signed [DATA_W-1:0] rd_data;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // The write lands at the accepting edge; reads are issued from S_DUMP after it,
   // and busy holds new items off until the dump is done, so no entry overlaps.
   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      rear_in    = rear_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      rem_in     = rem_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      last_in    = last_ff;
      full_in    = full_ff;
      empty_in   = empty_ff;
      err        = 1'b0;
      err_status = ST_EMPTY;
      wr.en      = 1'b0;
      wr.addr    = '0;
      wr.data    = req_value;
      rd_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action) inside
                  ACT_PUSH_LEFT, ACT_PUSH_RIGHT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        err        = 1'b1;
                        err_status = ST_FULL;
                     end else begin
                        wr.en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           front_in = '0;
                           rear_in  = '0;
                           wr.addr  = '0;
                        end else if (req_action == ACT_PUSH_LEFT) begin
                           front_in = prev_idx(front_ff);
                           wr.addr  = prev_idx(front_ff);
                        end else begin
                           rear_in = next_idx(rear_ff);
                           wr.addr = next_idx(rear_ff);
                        end
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        err        = 1'b1;
                        err_status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           front_in = '0;
                           rear_in  = '0;
                        end else if (req_action == ACT_POP_LEFT) begin
                           front_in = next_idx(front_ff);
                        end else begin
                           rear_in = prev_idx(rear_ff);
                        end
                     end
                  end
               endcase

               full_in  = (count_in == CNT_W'(DEPTH));
               empty_in = (count_in == '0);

               if (err || count_in == '0) begin
                  strobe_in = 1'b1;
                  status_in = err ? err_status : ST_EMPTY;
                  last_in   = 1'b1;
               end else begin
                  state_in  = S_DUMP;
                  rd_idx_in = front_in;
                  rem_in    = count_in;
               end
            end
         end
         S_DUMP: begin
            // issue one read a cycle; the result leaves with the read data
            rd_en     = 1'b1;
            strobe_in = 1'b1;
            status_in = ST_SHOWN;
            last_in   = (rem_ff == CNT_W'(1));
            rd_idx_in = next_idx(rd_idx_ff);
            rem_in    = rem_ff - 1'b1;
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= '0;
         rear_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         rear_ff   <= rear_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      full_ff   <= full_in;
      empty_ff  <= empty_in;
   end

   cdeq_ring u_ring (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_element  = (status_ff == ST_SHOWN) ? rd_data : '0;
   assign rsp_last     = last_ff;
   assign rsp_is_full  = full_ff;
   assign rsp_is_empty = empty_ff;

endmodule

[rtl/cdeq_ring.sv]
// Ring store: one write port and one read port with registered read data.
module cdeq_ring
   import cdeq_pkg::*;
(
   input  logic                     clock,
   input  cdeq_wr_type              wr,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cdeq_checker.sv]
// Port-level checks for the circular deque, bound to the top level.
module cdeq_checker
   import cdeq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic [1:0]               rsp_status,
   input logic                     rsp_last,
   input logic                     rsp_is_full,
   input logic                     rsp_is_empty
);

   // an accepted item either raises busy or answers at once
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted item neither dumped nor answered");

   // error and empty results stand alone
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_SHOWN |-> rsp_last)
      else $error("error or empty result without last");

   // a dump runs without gaps up to its last element
   a_dump_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_SHOWN && !rsp_last |=> rsp_strobe)
      else $error("gap inside a dump");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_empty |-> rsp_status == ST_EMPTY)
      else $error("empty flag with an element or full status");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_is_full && rsp_is_empty))
      else $error("full and empty both set");

endmodule

bind circular_deque_with_dump cdeq_checker u_cdeq_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last),
   .rsp_is_full  (rsp_is_full),
   .rsp_is_empty (rsp_is_empty)
);

[dv/testbench.sv]
// Self-checking testbench for the circular deque: predicted contents dumps against the block.
module testbench
   import cdeq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 410;
   localparam int REPORT_CAP   = 30;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic                     last;
      logic                     is_full;
      logic                     is_empty;
   } dump_word_type;

   // Deque model plus the queue of dump words still to arrive
   class deque_tracker;
      logic signed [DATA_W-1:0] store [DEPTH];
      logic [IDX_W-1:0]         head;
      logic [IDX_W-1:0]         tail;
      int                       fill;
      dump_word_type            awaited [$];
      int                       n_mismatch;
      int                       n_checked;
      int                       n_push;
      int                       n_pop;
      int                       n_full_refused;
      int                       n_empty_words;
      int                       peak_fill;

      function new();
         head = '0;
         tail = '0;
         fill = 0;
      endfunction

      function logic [IDX_W-1:0] wrap_fwd(logic [IDX_W-1:0] i);
         return IDX_W'((int'(i) + 1) % DEPTH);
      endfunction

      function logic [IDX_W-1:0] wrap_back(logic [IDX_W-1:0] i);
         return IDX_W'((int'(i) + DEPTH - 1) % DEPTH);
      endfunction

      function void add_word(status_type st, logic signed [DATA_W-1:0] el, logic lst);
         dump_word_type w;
         w.status   = st;
         w.element  = el;
         w.last     = lst;
         w.is_full  = (fill == DEPTH);
         w.is_empty = (fill == 0);
         awaited.push_back(w);
         if (st == ST_EMPTY) n_empty_words++;
      endfunction

      // Apply one accepted item and queue the results it causes
      function void note(logic [1:0] act, logic signed [DATA_W-1:0] val);
         logic [IDX_W-1:0] idx;
         if (act == ACT_PUSH_LEFT || act == ACT_PUSH_RIGHT) begin
            n_push++;
            if (fill == DEPTH) begin
               n_full_refused++;
               add_word(ST_FULL, '0, 1'b1);
               return;
            end
            if (fill == 0) begin
               head = '0;
               tail = '0;
               store[0] = val;
            end else if (act == ACT_PUSH_LEFT) begin
               head = wrap_back(head);
               store[head] = val;
            end else begin
               tail = wrap_fwd(tail);
               store[tail] = val;
            end
            fill++;
         end else begin
            n_pop++;
            if (fill == 0) begin
               add_word(ST_EMPTY, '0, 1'b1);
               return;
            end
            if (fill == 1) begin
               head = '0;
               tail = '0;
            end else if (act == ACT_POP_LEFT) begin
               head = wrap_fwd(head);
            end else begin
               tail = wrap_back(tail);
            end
            fill--;
         end
         if (fill > peak_fill) peak_fill = fill;
         if (fill == 0) begin
            add_word(ST_EMPTY, '0, 1'b1);
         end else begin
            idx = head;
            for (int n = 0; n < fill; n++) begin
               add_word(ST_SHOWN, store[idx], n == fill - 1);
               idx = wrap_fwd(idx);
            end
         end
      endfunction

      function void flag(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (got !== want) begin
            if (n_mismatch < REPORT_CAP)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_mismatch++;
         end
      endfunction

      function void check(logic [1:0] st, logic signed [DATA_W-1:0] el, logic lst,
                          logic full, logic empty);
         dump_word_type w;
         if (awaited.size() == 0) begin
            if (n_mismatch < REPORT_CAP)
               $display("%0t: result with nothing awaited, expected none, actual status %0d",
                        $time, st);
            n_mismatch++;
            return;
         end
         w = awaited.pop_front();
         n_checked++;
         flag("status", DATA_W'(w.status), DATA_W'(st));
         flag("element", w.element, el);
         flag("last", DATA_W'(w.last), DATA_W'(lst));
         flag("is_full", DATA_W'(w.is_full), DATA_W'(full));
         flag("is_empty", DATA_W'(w.is_empty), DATA_W'(empty));
      endfunction
   endclass

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     start      = 1'b0;
   logic [1:0]               req_action = ACT_PUSH_LEFT;
   logic signed [DATA_W-1:0] req_value  = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;
   logic                     rsp_is_full;
   logic                     rsp_is_empty;

   deque_tracker tracker = new();

   circular_deque_with_dump i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_is_full  (rsp_is_full),
      .rsp_is_empty (rsp_is_empty)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check(rsp_status, rsp_element, rsp_last, rsp_is_full, rsp_is_empty);
   end

   // Hold the item until an edge with busy low takes it
   task automatic send_item(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
      start      <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (busy);
      tracker.note(act, val);
   endtask

   task automatic idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.awaited.size() > 0) @(posedge clock);
   endtask

   initial begin
      int                       sent;
      int                       burst;
      int                       mode_left;
      bit                       fill_mode;
      bit                       is_push;
      bit                       right_side;
      logic [1:0]               act;
      logic signed [DATA_W-1:0] val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pops, extremes, sole-element pop, fill to full and refuse
      send_item(ACT_POP_LEFT, 32'sh1234_5678);
      send_item(ACT_POP_RIGHT, '1);
      send_item(ACT_PUSH_LEFT, 32'sh7fff_ffff);
      send_item(ACT_POP_LEFT, '0);
      send_item(ACT_PUSH_RIGHT, 32'sh8000_0000);
      send_item(ACT_PUSH_LEFT, -32'sd1);
      send_item(ACT_PUSH_RIGHT, '0);
      for (int k = 0; k < DEPTH - 3; k++)
         send_item(k[0] ? ACT_PUSH_LEFT : ACT_PUSH_RIGHT, DATA_W'(32'h5a5a_0000 + k));
      send_item(ACT_PUSH_LEFT, 32'sh7fff_ffff);
      send_item(ACT_PUSH_RIGHT, 32'sh8000_0000);
      send_item(ACT_POP_LEFT, '0);
      send_item(ACT_POP_RIGHT, '0);
      drain();

      sent      = 0;
      mode_left = 0;
      fill_mode = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            // Swing between filling and emptying so both ends are hit often
            if (mode_left == 0) begin
               fill_mode = ~fill_mode;
               mode_left = $urandom_range(10, 50);
            end
            mode_left--;
            is_push    = ($urandom_range(0, 99) < (fill_mode ? 80 : 20));
            right_side = 1'($urandom_range(0, 1));
            if (is_push)
               act = right_side ? ACT_PUSH_RIGHT : ACT_PUSH_LEFT;
            else
               act = right_side ? ACT_POP_RIGHT : ACT_POP_LEFT;
            case ($urandom_range(0, 9))
               0:       val = 32'sh7fff_ffff;
               1:       val = 32'sh8000_0000;
               2:       val = '0;
               3:       val = '1;
               default: val = $urandom();
            endcase
            send_item(act, val);
            sent++;
            if (sent == RANDOM_ITEMS / 2) drain();
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 20));
      end

      drain();
      repeat (DEPTH + 4) @(posedge clock);

      $display("Sent %0d items (%0d pushes, %0d pops), checked %0d results, peak fill %0d.",
               tracker.n_push + tracker.n_pop, tracker.n_push, tracker.n_pop,
               tracker.n_checked, tracker.peak_fill);
      $display("Pushes refused on a full store: %0d, empty answers: %0d.",
               tracker.n_full_refused, tracker.n_empty_words);
      if (tracker.awaited.size() > 0) begin
         $display("%0t: %0d results still awaited, expected 0, actual %0d", $time,
                  tracker.awaited.size(), tracker.awaited.size());
         tracker.n_mismatch++;
      end
      if (tracker.n_mismatch == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2ms;
      $display("%0t: run timed out", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule
